>>> src/jddm_pkg.sv
// Shared types, constants and saturation helpers for the joystick drive mixer.
package jddm_pkg;

   localparam int unsigned CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_MAX_WHEEL_SPEED     = 3'd0,
      REG_LINEAR_GAIN         = 3'd1,
      REG_ANGULAR_GAIN        = 3'd2,
      REG_INVERSE_RADIUS_GAIN = 3'd3,
      REG_HALF_TRACK_RATIO    = 3'd4,
      REG_RPM_GAIN            = 3'd5
   } reg_index_type;

   localparam logic [15:0] MAX_WHEEL_SPEED_RST     = 16'd1000;
   localparam logic [19:0] LINEAR_GAIN_RST         = 20'd65536;
   localparam logic [19:0] ANGULAR_GAIN_RST        = 20'd65536;
   localparam logic [19:0] INVERSE_RADIUS_GAIN_RST = 20'd65536;
   localparam logic [19:0] HALF_TRACK_RATIO_RST    = 20'd65536;
   localparam logic [19:0] RPM_GAIN_RST            = 20'd2445;

   localparam logic signed [8:0] HEAD_LIMIT = 9'sd180;
   localparam logic signed [8:0] HEAD_QUART = 9'sd90;

   // floor(n/45) = (n * DIV45_RECIP) >> DIV45_SHIFT for n < 2^23
   localparam logic [23:0] DIV45_RECIP = 24'd11930465;
   localparam int unsigned DIV45_SHIFT = 29;

   typedef enum logic [1:0] {
      QUAD_FWD_RIGHT,
      QUAD_FWD_LEFT,
      QUAD_REV_LEFT,
      QUAD_REV_RIGHT
   } quad_type;

   typedef struct packed {
      logic [15:0] max_wheel_speed;
      logic [19:0] linear_gain;
      logic [19:0] angular_gain;
      logic [19:0] inverse_radius_gain;
      logic [19:0] half_track_ratio;
      logic [19:0] rpm_gain;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] linear_speed;
      logic signed [31:0] angular_speed;
      logic signed [15:0] left_wheel_rpm;
      logic signed [15:0] right_wheel_rpm;
   } rsp_type;

   function automatic logic signed [31:0] sat_q16(input logic signed [40:0] x);
      logic fits;
      fits = (&x[40:31]) | ~(|x[40:31]);
      if (fits) begin
         return x[31:0];
      end else if (x[40]) begin
         return {1'b1, {31{1'b0}}};
      end else begin
         return {1'b0, {31{1'b1}}};
      end
   endfunction

   function automatic logic signed [15:0] sat_rpm(input logic signed [34:0] x);
      logic fits;
      fits = (&x[34:15]) | ~(|x[34:15]);
      if (fits) begin
         return x[15:0];
      end else if (x[34]) begin
         return {1'b1, {15{1'b0}}};
      end else begin
         return {1'b0, {15{1'b1}}};
      end
   endfunction

endpackage

>>> src/jddm_quadrant.sv
// Heading clamp, quadrant mixing and divide-by-45 stages (three stages).
module jddm_quadrant import jddm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic signed [8:0]  heading_degrees,
   input  logic [15:0]        deflection,
   input  cfg_type            cfg,
   output logic               out_valid,
   output logic signed [17:0] wheel_sum,
   output logic signed [17:0] wheel_diff,
   output logic [15:0]        out_deflection
);

   // stage 1
   logic signed [8:0] head_clamped;
   logic signed [8:0] k_wide;
   quad_type          quad_in, quad1_ff, quad2_ff;
   logic [22:0]       n_in, n_ff;
   logic [15:0]       defl1_ff, defl2_ff, defl3_ff;
   logic              valid1_ff, valid2_ff, valid3_ff;

   // stage 2
   logic [46:0]       recip_prod;
   logic [16:0]       q_in, q_ff;

   // stage 3
   logic signed [17:0] m_s, q_s, right_w, left_w;
   logic signed [17:0] sum_in, sum_ff, diff_in, diff_ff;

   always_comb begin
      if (heading_degrees > HEAD_LIMIT) begin
         head_clamped = HEAD_LIMIT;
      end else if (heading_degrees < -HEAD_LIMIT) begin
         head_clamped = -HEAD_LIMIT;
      end else begin
         head_clamped = heading_degrees;
      end

      if (head_clamped >= 9'sd0 && head_clamped <= HEAD_QUART) begin
         quad_in = QUAD_FWD_RIGHT;
         k_wide  = head_clamped;
      end else if (head_clamped > HEAD_QUART) begin
         quad_in = QUAD_FWD_LEFT;
         k_wide  = HEAD_LIMIT - head_clamped;
      end else if (head_clamped <= -HEAD_QUART) begin
         quad_in = QUAD_REV_LEFT;
         k_wide  = -HEAD_QUART - head_clamped;
      end else begin
         quad_in = QUAD_REV_RIGHT;
         k_wide  = -head_clamped;
      end

      // k*2M/90 is taken as k*M/45
      n_in = {16'b0, k_wide[6:0]} * {7'b0, cfg.max_wheel_speed};
   end

   always_comb begin
      recip_prod = {24'b0, n_ff} * {23'b0, DIV45_RECIP};
      q_in       = recip_prod[DIV45_SHIFT +: 17];
   end

   always_comb begin
      m_s = signed'({2'b00, cfg.max_wheel_speed});
      q_s = signed'({1'b0, q_ff});
      case (quad2_ff)
         QUAD_FWD_RIGHT: begin
            right_w = q_s - m_s;
            left_w  = m_s;
         end
         QUAD_FWD_LEFT: begin
            right_w = m_s;
            left_w  = q_s - m_s;
         end
         QUAD_REV_LEFT: begin
            right_w = q_s - m_s;
            left_w  = -m_s;
         end
         QUAD_REV_RIGHT: begin
            right_w = -m_s;
            left_w  = m_s - q_s;
         end
         default: begin
            right_w = '0;
            left_w  = '0;
         end
      endcase
      sum_in  = right_w + left_w;
      diff_in = right_w - left_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quad1_ff <= quad_in;
         n_ff     <= n_in;
         defl1_ff <= deflection;
         quad2_ff <= quad1_ff;
         q_ff     <= q_in;
         defl2_ff <= defl1_ff;
         sum_ff   <= sum_in;
         diff_ff  <= diff_in;
         defl3_ff <= defl2_ff;
      end
   end

   assign out_valid      = valid3_ff;
   assign wheel_sum      = sum_ff;
   assign wheel_diff     = diff_ff;
   assign out_deflection = defl3_ff;

endmodule

>>> src/jddm_kinematics.sv
// Deflection scaling, forward and inverse kinematics (five stages).
module jddm_kinematics import jddm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic signed [17:0] wheel_sum,
   input  logic signed [17:0] wheel_diff,
   input  logic [15:0]        deflection,
   input  cfg_type            cfg,
   output logic               out_valid,
   output logic signed [31:0] linear_speed,
   output logic signed [31:0] angular_speed,
   output logic signed [37:0] wheel_rate_right,
   output logic signed [37:0] wheel_rate_left
);

   logic signed [34:0] ps_in, ps_ff, pd_in, pd_ff;
   logic signed [55:0] pl_in, pl_ff, pa_in, pa_ff;
   logic signed [31:0] lin_in, lin6_ff, lin7_ff, lin8_ff;
   logic signed [31:0] ang_in, ang6_ff, ang7_ff, ang8_ff;
   logic signed [52:0] base_in, base_ff, turn_in, turn_ff;
   logic signed [53:0] wr_sum, wl_sum;
   logic signed [37:0] om_r_in, om_r_ff, om_l_in, om_l_ff;
   logic               valid4_ff, valid5_ff, valid6_ff, valid7_ff, valid8_ff;

   always_comb begin
      ps_in = 35'(wheel_sum)  * 35'(signed'({1'b0, deflection}));
      pd_in = 35'(wheel_diff) * 35'(signed'({1'b0, deflection}));

      pl_in = 56'(ps_ff) * 56'(signed'({1'b0, cfg.linear_gain}));
      pa_in = 56'(pd_ff) * 56'(signed'({1'b0, cfg.angular_gain}));

      // arithmetic shift by 15 is a floor
      lin_in = sat_q16(signed'(pl_ff[55:15]));
      ang_in = sat_q16(signed'(pa_ff[55:15]));

      base_in = 53'(lin6_ff) * 53'(signed'({1'b0, cfg.inverse_radius_gain}));
      turn_in = 53'(ang6_ff) * 53'(signed'({1'b0, cfg.half_track_ratio}));

      wr_sum  = 54'(base_ff) + 54'(turn_ff);
      wl_sum  = 54'(base_ff) - 54'(turn_ff);
      om_r_in = signed'(wr_sum[53:16]);
      om_l_in = signed'(wl_sum[53:16]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
         valid7_ff <= 1'b0;
         valid8_ff <= 1'b0;
      end else if (advance) begin
         valid4_ff <= in_valid;
         valid5_ff <= valid4_ff;
         valid6_ff <= valid5_ff;
         valid7_ff <= valid6_ff;
         valid8_ff <= valid7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ps_ff   <= ps_in;
         pd_ff   <= pd_in;
         pl_ff   <= pl_in;
         pa_ff   <= pa_in;
         lin6_ff <= lin_in;
         ang6_ff <= ang_in;
         base_ff <= base_in;
         turn_ff <= turn_in;
         lin7_ff <= lin6_ff;
         ang7_ff <= ang6_ff;
         om_r_ff <= om_r_in;
         om_l_ff <= om_l_in;
         lin8_ff <= lin7_ff;
         ang8_ff <= ang7_ff;
      end
   end

   assign out_valid        = valid8_ff;
   assign linear_speed     = lin8_ff;
   assign angular_speed    = ang8_ff;
   assign wheel_rate_right = om_r_ff;
   assign wheel_rate_left  = om_l_ff;

endmodule

>>> src/jddm_rpm.sv
// RPM gain, truncation toward zero and saturation (two stages).
module jddm_rpm import jddm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic signed [31:0] linear_speed,
   input  logic signed [31:0] angular_speed,
   input  logic signed [37:0] wheel_rate_right,
   input  logic signed [37:0] wheel_rate_left,
   input  cfg_type            cfg,
   output logic               out_valid,
   output rsp_type            out_data
);

   logic signed [58:0] pr_in, pr_ff, pl_in, pl_ff;
   logic signed [58:0] tr, tl;
   logic signed [31:0] lin9_ff, ang9_ff;
   rsp_type            res_in, res_ff;
   logic               valid9_ff, valid10_ff;

   always_comb begin
      pr_in = 59'(wheel_rate_right) * 59'(signed'({1'b0, cfg.rpm_gain}));
      pl_in = 59'(wheel_rate_left)  * 59'(signed'({1'b0, cfg.rpm_gain}));

      // bias negatives so the arithmetic shift rounds toward zero
      tr = pr_ff + (pr_ff[58] ? 59'(24'hFFFFFF) : 59'(0));
      tl = pl_ff + (pl_ff[58] ? 59'(24'hFFFFFF) : 59'(0));

      res_in.linear_speed    = lin9_ff;
      res_in.angular_speed   = ang9_ff;
      res_in.left_wheel_rpm  = sat_rpm(signed'(tl[58:24]));
      res_in.right_wheel_rpm = sat_rpm(signed'(tr[58:24]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid9_ff  <= 1'b0;
         valid10_ff <= 1'b0;
      end else if (advance) begin
         valid9_ff  <= in_valid;
         valid10_ff <= valid9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pr_ff   <= pr_in;
         pl_ff   <= pl_in;
         lin9_ff <= linear_speed;
         ang9_ff <= angular_speed;
         res_ff  <= res_in;
      end
   end

   assign out_valid = valid10_ff;
   assign out_data  = res_ff;

endmodule

>>> src/jddm_out_buf.sv
// Output register with skid entry; holds the pipeline while the skid is full.
module jddm_out_buf import jddm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    pipe_valid,
   input  rsp_type pipe_data,
   input  logic    rsp_stall,
   output logic    advance,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_data_ff, skid_data_ff;
   logic    out_free;

   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign advance  = ~skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (out_free) begin
         out_valid_ff <= pipe_valid;
      end else if (pipe_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (out_free) begin
         out_data_ff <= pipe_data;
      end else begin
         skid_data_ff <= pipe_data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> src/joystick_differential_drive_mixer.sv
// Top level: joystick heading/deflection to reference speeds and wheel RPM.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  heading_degrees, deflection
//   rsp      out        rsp_valid / rsp_stall  linear/angular speed, wheel RPMs
//   csr      in/out     APB psel/penable       six gain registers at 4*i
//
// One transaction per cycle while the skid entry is empty. Ten arithmetic stages
// plus output register, set by the multiplier chain, each followed by a register.
// Reset clears valid bits and restores the register defaults; no clearing pass.
// A stalled result parks in the skid entry and req_stall rises the next cycle;
// the whole pipeline then holds until the skid entry drains.
module joystick_differential_drive_mixer import jddm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [8:0]     req_heading_degrees,
   input  logic [15:0]           req_deflection,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_linear_speed,
   output logic signed [31:0]    rsp_angular_speed,
   output logic signed [15:0]    rsp_left_wheel_rpm,
   output logic signed [15:0]    rsp_right_wheel_rpm,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type            cfg_ff;
   reg_index_type      reg_sel;
   logic               csr_write;
   logic               advance;

   logic               quad_valid;
   logic signed [17:0] wheel_sum, wheel_diff;
   logic [15:0]        quad_defl;

   logic               kin_valid;
   logic signed [31:0] kin_lin, kin_ang;
   logic signed [37:0] om_right, om_left;

   logic               rpm_valid;
   rsp_type            rpm_data, rsp_data;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_wheel_speed     <= MAX_WHEEL_SPEED_RST;
         cfg_ff.linear_gain         <= LINEAR_GAIN_RST;
         cfg_ff.angular_gain        <= ANGULAR_GAIN_RST;
         cfg_ff.inverse_radius_gain <= INVERSE_RADIUS_GAIN_RST;
         cfg_ff.half_track_ratio    <= HALF_TRACK_RATIO_RST;
         cfg_ff.rpm_gain            <= RPM_GAIN_RST;
      end else if (csr_write) begin
         case (reg_sel)
            REG_MAX_WHEEL_SPEED:     cfg_ff.max_wheel_speed     <= csr_pwdata[15:0];
            REG_LINEAR_GAIN:         cfg_ff.linear_gain         <= csr_pwdata[19:0];
            REG_ANGULAR_GAIN:        cfg_ff.angular_gain        <= csr_pwdata[19:0];
            REG_INVERSE_RADIUS_GAIN: cfg_ff.inverse_radius_gain <= csr_pwdata[19:0];
            REG_HALF_TRACK_RATIO:    cfg_ff.half_track_ratio    <= csr_pwdata[19:0];
            REG_RPM_GAIN:            cfg_ff.rpm_gain            <= csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MAX_WHEEL_SPEED:     csr_prdata = {16'b0, cfg_ff.max_wheel_speed};
         REG_LINEAR_GAIN:         csr_prdata = {12'b0, cfg_ff.linear_gain};
         REG_ANGULAR_GAIN:        csr_prdata = {12'b0, cfg_ff.angular_gain};
         REG_INVERSE_RADIUS_GAIN: csr_prdata = {12'b0, cfg_ff.inverse_radius_gain};
         REG_HALF_TRACK_RATIO:    csr_prdata = {12'b0, cfg_ff.half_track_ratio};
         REG_RPM_GAIN:            csr_prdata = {12'b0, cfg_ff.rpm_gain};
         default:                 csr_prdata = '0;
      endcase
   end

   assign req_stall = ~advance;

   jddm_quadrant u_quadrant (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (req_valid),
      .heading_degrees (req_heading_degrees),
      .deflection      (req_deflection),
      .cfg             (cfg_ff),
      .out_valid       (quad_valid),
      .wheel_sum       (wheel_sum),
      .wheel_diff      (wheel_diff),
      .out_deflection  (quad_defl)
   );

   jddm_kinematics u_kinematics (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .in_valid         (quad_valid),
      .wheel_sum        (wheel_sum),
      .wheel_diff       (wheel_diff),
      .deflection       (quad_defl),
      .cfg              (cfg_ff),
      .out_valid        (kin_valid),
      .linear_speed     (kin_lin),
      .angular_speed    (kin_ang),
      .wheel_rate_right (om_right),
      .wheel_rate_left  (om_left)
   );

   jddm_rpm u_rpm (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .in_valid         (kin_valid),
      .linear_speed     (kin_lin),
      .angular_speed    (kin_ang),
      .wheel_rate_right (om_right),
      .wheel_rate_left  (om_left),
      .cfg              (cfg_ff),
      .out_valid        (rpm_valid),
      .out_data         (rpm_data)
   );

   jddm_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .pipe_valid (rpm_valid),
      .pipe_data  (rpm_data),
      .rsp_stall  (rsp_stall),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   assign rsp_linear_speed    = rsp_data.linear_speed;
   assign rsp_angular_speed   = rsp_data.angular_speed;
   assign rsp_left_wheel_rpm  = rsp_data.left_wheel_rpm;
   assign rsp_right_wheel_rpm = rsp_data.right_wheel_rpm;

endmodule

>>> verif/tb_joystick_differential_drive_mixer.sv
// Self-checking testbench for the joystick differential-drive mixer: directed and random samples.
module tb_joystick_differential_drive_mixer;
   import jddm_pkg::*;

   localparam int     CYCLE_LIMIT  = 400000;
   localparam int     PIPE_LATENCY = 11;
   localparam int     RANDOM_ITEMS = 1250;
   localparam int     RANDOM_PHASES = 6;
   localparam longint Q16_MAX = 64'sd2147483647;
   localparam longint Q16_MIN = -64'sd2147483648;
   localparam longint RPM_MAX = 64'sd32767;
   localparam longint RPM_MIN = -64'sd32768;
   // index just past the register file; writes there must be ignored
   localparam logic [2:0] UNUSED_REG_INDEX = 3'd6;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_BURSTY
   } stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [8:0]     req_heading_degrees = '0;
   logic [15:0]           req_deflection = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [31:0]    rsp_linear_speed;
   logic signed [31:0]    rsp_angular_speed;
   logic signed [15:0]    rsp_left_wheel_rpm;
   logic signed [15:0]    rsp_right_wheel_rpm;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   cfg_type        drive_cfg;
   rsp_type        drive_expect_q[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   bit             sender_gaps = 1'b1;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_mode_left = 0;

   joystick_differential_drive_mixer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_heading_degrees (req_heading_degrees),
      .req_deflection      (req_deflection),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_linear_speed    (rsp_linear_speed),
      .rsp_angular_speed   (rsp_angular_speed),
      .rsp_left_wheel_rpm  (rsp_left_wheel_rpm),
      .rsp_right_wheel_rpm (rsp_right_wheel_rpm),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #4 clock = ~clock;

   initial begin
      drive_cfg.max_wheel_speed     = MAX_WHEEL_SPEED_RST;
      drive_cfg.linear_gain         = LINEAR_GAIN_RST;
      drive_cfg.angular_gain        = ANGULAR_GAIN_RST;
      drive_cfg.inverse_radius_gain = INVERSE_RADIUS_GAIN_RST;
      drive_cfg.half_track_ratio    = HALF_TRACK_RATIO_RST;
      drive_cfg.rpm_gain            = RPM_GAIN_RST;
   end

   function automatic longint clamp(input longint x, input longint lo, input longint hi);
      if (x < lo) begin
         return lo;
      end else if (x > hi) begin
         return hi;
      end
      return x;
   endfunction

   function automatic longint shift24_toward_zero(input longint x);
      if (x < 0) begin
         return -((-x) >>> 24);
      end
      return x >>> 24;
   endfunction

   // Heading clamp, wheel mixing, forward then inverse kinematics and RPM gain, all in 64-bit signed.
   function automatic rsp_type predict_drive(input logic signed [8:0] heading,
                                             input logic [15:0] deflection);
      longint h, m, defl, right_spd, left_spd, lin, ang, base, turn, om_r, om_l;
      longint g_lin, g_ang, g_inv, g_half, g_rpm;
      rsp_type r;
      h      = heading;
      m      = drive_cfg.max_wheel_speed;
      defl   = deflection;
      g_lin  = drive_cfg.linear_gain;
      g_ang  = drive_cfg.angular_gain;
      g_inv  = drive_cfg.inverse_radius_gain;
      g_half = drive_cfg.half_track_ratio;
      g_rpm  = drive_cfg.rpm_gain;
      h = clamp(h, -180, 180);
      if (h >= 0 && h <= 90) begin
         right_spd = (h * 2 * m) / 90 - m;
         left_spd  = m;
      end else if (h > 90) begin
         right_spd = m;
         left_spd  = ((180 - h) * 2 * m) / 90 - m;
      end else if (h <= -90) begin
         right_spd = ((-90 - h) * 2 * m) / 90 - m;
         left_spd  = -m;
      end else begin
         right_spd = -m;
         left_spd  = m - ((-h) * 2 * m) / 90;
      end
      lin  = clamp((((right_spd + left_spd) * defl) * g_lin) >>> 15, Q16_MIN, Q16_MAX);
      ang  = clamp((((right_spd - left_spd) * defl) * g_ang) >>> 15, Q16_MIN, Q16_MAX);
      base = lin * g_inv;
      turn = ang * g_half;
      om_r = (base + turn) >>> 16;
      om_l = (base - turn) >>> 16;
      r.linear_speed    = lin[31:0];
      r.angular_speed   = ang[31:0];
      r.left_wheel_rpm  = 16'(clamp(shift24_toward_zero(om_l * g_rpm), RPM_MIN, RPM_MAX));
      r.right_wheel_rpm = 16'(clamp(shift24_toward_zero(om_r * g_rpm), RPM_MIN, RPM_MAX));
      return r;
   endfunction

   function automatic logic [31:0] rand_reg_value(input int width);
      logic [31:0] all_ones;
      all_ones = (32'd1 << width) - 1;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return all_ones;
         2: return $urandom;
         3, 4: return $urandom_range(0, 32'd131072) & all_ones;
         default: return $urandom & all_ones;
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, drive_expect_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver back-pressure: the pattern is picked at random and changes when its countdown runs out.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      <= stall_mode_type'($urandom_range(0, 3));
            stall_mode_left <= $urandom_range(64, 256);
         end else begin
            stall_mode_left <= stall_mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 30);
            STALL_PERIODIC: rsp_stall <= (cycle_count % 3 == 0);
            default:        rsp_stall <= ($urandom_range(0, 11) == 0) ? ~rsp_stall : rsp_stall;
         endcase
      end
   end

   task automatic report_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_expect_q.size() == 0) begin
            $display("%0t: unexpected transaction, lin %0d ang %0d left %0d right %0d", $time,
                     rsp_linear_speed, rsp_angular_speed, rsp_left_wheel_rpm,
                     rsp_right_wheel_rpm);
            mismatch_count++;
         end else begin
            want = drive_expect_q.pop_front();
            report_field("linear_speed", want.linear_speed, rsp_linear_speed);
            report_field("angular_speed", want.angular_speed, rsp_angular_speed);
            report_field("left_wheel_rpm", want.left_wheel_rpm, rsp_left_wheel_rpm);
            report_field("right_wheel_rpm", want.right_wheel_rpm, rsp_right_wheel_rpm);
         end
      end
   end

   // Holds valid until the transaction is taken, then maybe ends the burst.
   task automatic send_sample(input logic signed [8:0] heading, input logic [15:0] deflection);
      req_valid           <= 1'b1;
      req_heading_degrees <= heading;
      req_deflection      <= deflection;
      do @(posedge clock); while (req_stall);
      drive_expect_q.push_back(predict_drive(heading, deflection));
      if (sender_gaps) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_gain_reg(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         REG_MAX_WHEEL_SPEED:     drive_cfg.max_wheel_speed     = value[15:0];
         REG_LINEAR_GAIN:         drive_cfg.linear_gain         = value[19:0];
         REG_ANGULAR_GAIN:        drive_cfg.angular_gain        = value[19:0];
         REG_INVERSE_RADIUS_GAIN: drive_cfg.inverse_radius_gain = value[19:0];
         REG_HALF_TRACK_RATIO:    drive_cfg.half_track_ratio    = value[19:0];
         REG_RPM_GAIN:            drive_cfg.rpm_gain            = value[19:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all_regs(input logic [31:0] speed, input logic [31:0] gain);
      write_gain_reg(REG_MAX_WHEEL_SPEED, speed);
      write_gain_reg(REG_LINEAR_GAIN, gain);
      write_gain_reg(REG_ANGULAR_GAIN, gain);
      write_gain_reg(REG_INVERSE_RADIUS_GAIN, gain);
      write_gain_reg(REG_HALF_TRACK_RATIO, gain);
      write_gain_reg(REG_RPM_GAIN, gain);
   endtask

   // Reset settings; quadrant edges, out-of-range headings and deflection extremes.
   task automatic test_quadrant_headings();
      int headings[20] = '{-256, -181, -180, -179, -135, -91, -90, -89, -45, -1,
                           0, 1, 45, 89, 90, 91, 179, 180, 181, 255};
      logic [15:0] deflections[5] = '{16'd32768, 16'd65535, 16'd0, 16'd1, 16'd16384};
      foreach (headings[i]) begin
         send_sample(9'(headings[i]), deflections[i % 5]);
      end
      wait_for_results();
   endtask

   // Full-scale settings exercise saturation, with a write to the unused index; then all-zero settings.
   task automatic test_saturation_extremes();
      write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      write_gain_reg(UNUSED_REG_INDEX, 32'h0000_0123);
      send_sample(9'sd0, 16'hFFFF);
      send_sample(9'sd90, 16'hFFFF);
      send_sample(-9'sd90, 16'hFFFF);
      send_sample(-9'sd180, 16'd32768);
      wait_for_results();
      write_all_regs(32'd0, 32'd0);
      send_sample(9'sd45, 16'd32768);
      wait_for_results();
   endtask

   task automatic test_random_settings();
      logic signed [8:0] heading;
      logic [15:0]       deflection;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            write_gain_reg(REG_MAX_WHEEL_SPEED, MAX_WHEEL_SPEED_RST);
            write_gain_reg(REG_LINEAR_GAIN, LINEAR_GAIN_RST);
            write_gain_reg(REG_ANGULAR_GAIN, ANGULAR_GAIN_RST);
            write_gain_reg(REG_INVERSE_RADIUS_GAIN, INVERSE_RADIUS_GAIN_RST);
            write_gain_reg(REG_HALF_TRACK_RATIO, HALF_TRACK_RATIO_RST);
            write_gain_reg(REG_RPM_GAIN, RPM_GAIN_RST);
         end else if (phase == 1) begin
            write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
         end else begin
            write_gain_reg(REG_MAX_WHEEL_SPEED, rand_reg_value(16));
            write_gain_reg(REG_LINEAR_GAIN, rand_reg_value(20));
            write_gain_reg(REG_ANGULAR_GAIN, rand_reg_value(20));
            write_gain_reg(REG_INVERSE_RADIUS_GAIN, rand_reg_value(20));
            write_gain_reg(REG_HALF_TRACK_RATIO, rand_reg_value(20));
            write_gain_reg(REG_RPM_GAIN, rand_reg_value(20));
         end
         sender_gaps = (phase % 3 != 2);
         burst_left  = 0;
         for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
            if ($urandom_range(0, 99) < 85) begin
               heading = 9'($urandom_range(0, 360) - 180);
            end else begin
               heading = 9'($urandom_range(0, 511));
            end
            case ($urandom_range(0, 9))
               0:       deflection = 16'd32768;
               1:       deflection = 16'($urandom);
               default: deflection = 16'($urandom_range(0, 32768));
            endcase
            send_sample(heading, deflection);
         end
         wait_for_results();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_quadrant_headings();
      test_saturation_extremes();
      test_random_settings();
      wait_for_results();
      if (mismatch_count == 0 && drive_expect_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> files.f
src/jddm_pkg.sv
src/jddm_quadrant.sv
src/jddm_kinematics.sv
src/jddm_rpm.sv
src/jddm_out_buf.sv
src/joystick_differential_drive_mixer.sv
verif/tb_joystick_differential_drive_mixer.sv
